FILE: hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, round constants and the sigma functions of the compression.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha256_pkg;

  typedef logic [0:7][31:0] hash_t;

  localparam hash_t InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [0:63][31:0] RoundK = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PadByte = 8'h80;

  // Byte push and compression control from the sequencer
  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       start;
    logic       reinit;
  } comp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } comp_stat_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

FILE: hw/rtl/sha256_if.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher channels
// Valid/ready channels for message items and digest words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

FILE: hw/rtl/sha256_compress.sv
// ----------------------------------------------------------------------------
// SHA-256 compression unit
// Byte-fed block buffer that doubles as the rolling schedule, one round per
// cycle for every round constant, then a final add into the hash words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_compress (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha256_pkg::comp_ctrl_t ctrl_i,
  output sha256_pkg::comp_stat_t stat_o,
  output sha256_pkg::hash_t      hash_o
);

  logic [31:0]       w_q [16];
  logic [31:0]       v_q [8];
  logic [5:0]        round_q;
  logic              busy_q;
  logic              fin_q;
  sha256_pkg::hash_t hash_q;

  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  always_comb begin
    if (round_q < 6'd16) begin
      w_new = w_q[0];
    end else begin
      w_new = sha256_pkg::small_sigma1(w_q[14]) + w_q[9] +
              sha256_pkg::small_sigma0(w_q[1]) + w_q[0];
    end
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1  = v_q[7] + sha256_pkg::big_sigma1(v_q[4]) + ch + sha256_pkg::RoundK[round_q] + w_new;
    t2  = sha256_pkg::big_sigma0(v_q[0]) + maj;
  end

  // Block buffer: bytes shift in big-endian, words shift out during rounds
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_q[15] <= {w_q[15][23:0], ctrl_i.data};
    end else if (busy_q) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= hash_q[i];
      end
    end else if (busy_q) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      fin_q   <= 1'b0;
      round_q <= '0;
      hash_q  <= sha256_pkg::InitHash;
    end else begin
      fin_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q  <= 1'b1;
        round_q <= '0;
      end else if (busy_q) begin
        round_q <= round_q + 6'd1;
        if (round_q == 6'd63) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (ctrl_i.reinit) begin
        hash_q <= sha256_pkg::InitHash;
      end else if (fin_q) begin
        for (int j = 0; j < 8; j++) begin
          hash_q[j] <= hash_q[j] + v_q[j];
        end
      end
    end
  end

  assign stat_o.busy = busy_q | fin_q;
  assign stat_o.done = fin_q;
  assign hash_o      = hash_q;

endmodule

FILE: hw/rtl/sha256_message_hasher_core.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher core
// Message bytes are taken only while idle; a byte that completes a 64-byte block
// starts a compression (64 rounds of the shared round unit plus one final add).
// A finish transaction pushes 9 to 72 padding bytes at one per cycle, pausing for
// each of its one or two compressions, then 8 digest words, one per ready cycle.
// Reset clears the sequencer and loads the initial hash values; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_message_hasher_core (
  input  logic clk_i,
  input  logic rst_ni,
  sha256_in_if.sink    in_i,
  sha256_out_if.source out_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPad  = 2'd1;
  localparam logic [1:0] StComp = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic        pad_act_q, pad_act_d;
  logic        first_q, first_d;
  logic        lenm_q, lenm_d;
  logic [2:0]  lenc_q, lenc_d;
  logic        pad_done_q, pad_done_d;
  logic [2:0]  idx_q, idx_d;

  sha256_pkg::comp_ctrl_t ctrl;
  sha256_pkg::comp_stat_t stat;
  sha256_pkg::hash_t      hash;

  sha256_compress u_comp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .hash_o (hash)
  );

  assign in_i.ready        = (state_q == StIdle);
  assign out_o.valid       = (state_q == StOut);
  assign out_o.digest_word = hash[idx_q];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == 3'd7);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    bits_d     = bits_q;
    pad_act_d  = pad_act_q;
    first_d    = first_q;
    lenm_d     = lenm_q;
    lenc_d     = lenc_q;
    pad_done_d = pad_done_q;
    idx_d      = idx_q;
    ctrl       = '0;

    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          if (!in_i.kind) begin
            ctrl.push = 1'b1;
            ctrl.data = in_i.data_byte;
            bits_d    = bits_q + 64'd8;
          end else begin
            state_d    = StPad;
            pad_act_d  = 1'b1;
            first_d    = 1'b1;
            lenm_d     = 1'b0;
            lenc_d     = '0;
            pad_done_d = 1'b0;
          end
        end
      end
      StPad: begin
        ctrl.push = 1'b1;
        priority if (first_q) begin
          ctrl.data = sha256_pkg::PadByte;
          first_d   = 1'b0;
        end else if (lenm_q || fill_q == 6'd56) begin
          // Length field goes out most significant byte first
          ctrl.data = bits_q[63:56];
          bits_d    = {bits_q[55:0], 8'h00};
          lenm_d    = 1'b1;
          lenc_d    = lenc_q + 3'd1;
          if (lenc_q == 3'd7) begin
            pad_done_d = 1'b1;
          end
        end else begin
          ctrl.data = 8'h00;
        end
      end
      StComp: begin
        if (stat.done) begin
          priority if (pad_done_q) begin
            state_d = StOut;
          end else if (pad_act_q) begin
            state_d = StPad;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StOut: begin
        if (out_o.ready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            ctrl.reinit = 1'b1;
            bits_d      = '0;
            pad_act_d   = 1'b0;
            pad_done_d  = 1'b0;
            state_d     = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // Advance the fill count; a full block kicks off the compression
    if (ctrl.push) begin
      fill_d = fill_q + 6'd1;
      if (fill_q == 6'd63) begin
        ctrl.start = 1'b1;
        state_d    = StComp;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      fill_q     <= '0;
      bits_q     <= '0;
      pad_act_q  <= 1'b0;
      first_q    <= 1'b0;
      lenm_q     <= 1'b0;
      lenc_q     <= '0;
      pad_done_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      bits_q     <= bits_d;
      pad_act_q  <= pad_act_d;
      first_q    <= first_d;
      lenm_q     <= lenm_d;
      lenc_q     <= lenc_d;
      pad_done_q <= pad_done_d;
      idx_q      <= idx_d;
    end
  end

  a_ready_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !stat.busy)
    else $error("input ready while the compression runs");

  a_out_block_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (fill_q == 6'd0 && bits_q == 64'd0 && !stat.busy))
    else $error("digest offered with a partial block or pending length");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_word) |=> (in_i.ready && idx_q == 3'd0))
    else $error("sequencer did not return to idle after the last digest word");

  a_done_leaves_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StComp && stat.done) |=> state_q != StComp)
    else $error("compression finished but the sequencer stayed waiting");

endmodule

FILE: test/tb_sha256_message_hasher_core.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher core testbench
// Streams message bytes and finish transactions into the hasher and checks
// every digest word against an in-bench SHA-256 predictor. A scoreboard class
// holds the expected words. A directed opening comes first, then random messages
// under four phases of source idling and sink stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sha256_message_hasher_core;

  localparam logic KindByte   = 1'b0;
  localparam logic KindFinish = 1'b1;
  localparam logic [7:0] PadMark = 8'h80;
  localparam int unsigned PhaseItems = 57;
  localparam int unsigned SettleCycles = 100;

  localparam logic [0:7][31:0] StartHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [0:63][31:0] RoundConst = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_entry_t;

  class sha256_digest_scoreboard;
    logic [31:0]   hash_state [8];
    logic [63:0]   msg_bits;
    logic [7:0]    block_buf [64];
    int unsigned   fill_cnt;
    digest_entry_t digest_words_due [$];
    int unsigned   errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      for (int j = 0; j < 8; j++) begin
        hash_state[j] = StartHash[j];
      end
      msg_bits = '0;
      fill_cnt = 0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] v [8];
      logic [31:0] w [64];
      logic [31:0] t1;
      logic [31:0] t2;
      for (int r = 0; r < 16; r++) begin
        w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
      end
      for (int r = 16; r < 64; r++) begin
        w[r] = (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
             + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
      end
      for (int j = 0; j < 8; j++) begin
        v[j] = hash_state[j];
      end
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[r] + w[r];
        t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) begin
        hash_state[j] = hash_state[j] + v[j];
      end
    endfunction

    function void push_byte(logic [7:0] b);
      block_buf[fill_cnt] = b;
      fill_cnt++;
      if (fill_cnt == 64) begin
        compress();
        fill_cnt = 0;
      end
    endfunction

    // Absorb one accepted input transaction; a finish pads and queues the digest.
    function void absorb_item(logic kind, logic [7:0] data_byte);
      digest_entry_t e;
      if (kind == KindByte) begin
        msg_bits = msg_bits + 64'd8;
        push_byte(data_byte);
      end else begin
        push_byte(PadMark);
        while (fill_cnt != 56) begin
          push_byte(8'h00);
        end
        for (int k = 0; k < 8; k++) begin
          push_byte(8'((msg_bits >> (56 - 8 * k)) & 64'hff));
        end
        for (int k = 0; k < 8; k++) begin
          e.word  = hash_state[k];
          e.index = 3'(k);
          e.last  = (k == 7);
          digest_words_due.insert(digest_words_due.size(), e);
        end
        restart();
      end
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_word(logic [31:0] word, logic [2:0] index, logic last);
      digest_entry_t e;
      if (digest_words_due.size() == 0) begin
        report_mismatch($sformatf("unexpected digest word %h index %0d", word, index));
      end else begin
        e = digest_words_due.pop_front();
        if (word !== e.word)
          report_mismatch($sformatf("digest_word got %h expected %h", word, e.word));
        if (index !== e.index)
          report_mismatch($sformatf("word_index got %0d expected %0d", index, e.index));
        if (last !== e.last)
          report_mismatch($sformatf("last_word got %b expected %b", last, e.last));
      end
    endtask

    function int unsigned pending();
      return digest_words_due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  sha256_digest_scoreboard sb;

  sha256_in_if  in_if ();
  sha256_out_if out_if ();

  sha256_message_hasher_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("sha256_message_hasher_core regression: fail");
    $finish;
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_word(out_if.digest_word, out_if.word_index, out_if.last_word);
  end

  // Hold valid high until the transaction is taken at a rising edge.
  task automatic send_item(logic kind, logic [7:0] data_byte);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.data_byte <= data_byte;
    do @(posedge clk_i); while (!in_if.ready);
    sb.absorb_item(kind, data_byte);
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned msg_len;
    int unsigned roll;
    int unsigned phase_count;
    int unsigned msg_num;
    sb = new();
    rst_ni           = 1'b0;
    src_idle_pct     = 0;
    snk_stall_pct    = 0;
    in_if.valid      = 1'b0;
    in_if.kind       = KindByte;
    in_if.data_byte  = 8'h00;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty message, then a second empty one back to back; data_byte is ignored.
    send_item(KindFinish, 8'h00);
    send_item(KindFinish, 8'hff);
    // "abc"
    send_item(KindByte, 8'h61);
    send_item(KindByte, 8'h62);
    send_item(KindByte, 8'h63);
    send_item(KindFinish, 8'h3c);
    // Byte extremes
    send_item(KindByte, 8'h00);
    send_item(KindByte, 8'hff);
    send_item(KindFinish, 8'ha5);
    send_item(KindByte, 8'hff);
    send_item(KindFinish, 8'h5a);
    send_item(KindByte, 8'h55);
    send_item(KindByte, 8'haa);
    send_item(KindByte, 8'h80);
    send_item(KindFinish, 8'h01);
    pause_until_drained();

    // Random messages; padding boundaries at 55/56 and block edges are favored.
    msg_num = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
        default: begin src_idle_pct = 9; snk_stall_pct = 9; end
      endcase
      phase_count = 0;
      while (phase_count < PhaseItems) begin
        roll = $urandom_range(99);
        if (msg_num == 0)
          msg_len = 55;
        else if (msg_num == 1)
          msg_len = 56;
        else if (roll < 45)
          msg_len = $urandom_range(12);
        else if (roll < 75)
          case ($urandom_range(6))
            0: msg_len = 55;
            1: msg_len = 56;
            2: msg_len = 57;
            3: msg_len = 63;
            4: msg_len = 64;
            5: msg_len = 119;
            default: msg_len = 120;
          endcase
        else
          msg_len = $urandom_range(130);
        // Trim the closing message of a phase to what is left of its budget
        if (msg_num > 1 && msg_len + 1 > PhaseItems - phase_count)
          msg_len = PhaseItems - phase_count - 1;
        for (int i = 0; i < msg_len; i++) begin
          send_item(KindByte, 8'($urandom_range(255)));
        end
        send_item(KindFinish, 8'($urandom_range(255)));
        phase_count += msg_len + 1;
        msg_num++;
      end
      pause_until_drained();
    end

    repeat (SettleCycles) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sha256_message_hasher_core regression: pass");
    end else begin
      $display("sha256_message_hasher_core regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_if.sv
hw/rtl/sha256_compress.sv
hw/rtl/sha256_message_hasher_core.sv
test/tb_sha256_message_hasher_core.sv
